// File: rtl/lz4bd_pkg.sv
// Shared constants and codes for the LZ4 block decompressor.
package lz4bd_pkg;

    localparam int HISTORY_DEPTH_DEF = 65536;
    localparam int OUT_LANES_DEF     = 8;
    localparam int MAX_OUTPUT_DEF    = 16777216;

    localparam int BYTE_W   = 8;
    localparam int LEN_W    = 25;
    localparam int COUNT_W  = 4;
    localparam int STATUS_W = 3;
    localparam int PORT_LANES = 8;

    localparam logic [3:0] NIB_EXT   = 4'd15;
    localparam logic [7:0] BYTE_EXT  = 8'd255;
    localparam int         MIN_MATCH = 4;

    localparam logic [STATUS_W-1:0] ST_DATA   = 3'd0;
    localparam logic [STATUS_W-1:0] ST_DONE   = 3'd1;
    localparam logic [STATUS_W-1:0] ST_TRUNC  = 3'd2;
    localparam logic [STATUS_W-1:0] ST_BADOFF = 3'd3;
    localparam logic [STATUS_W-1:0] ST_OVF    = 3'd4;

endpackage

// File: rtl/lz4_block_decompressor.sv
// LZ4 block decompressor top level with history memory and copy engine.
//
// Usage: feed one compressed byte per request on the input channel (data_byte,
// is_last on the block's final byte). Results leave on the output channel as
// chunks of up to eight bytes (byte_count valid lanes from out_byte0 upward,
// status data), and the block's last byte adds one closing result with
// end_of_block high and status done, truncated, bad offset or overflow.
// Tokens, lengths and offset bytes are taken one per request; a literal is
// written to history and loaded into the output register as it is taken. A
// match copies one byte per cycle within a chunk through the single-port-read
// history memory (registered read, same-cycle read/write forwarded); each
// chunk is read and written back, then loaded into the output register, which
// waits while the receiver stalls. The closing result is loaded in a close
// state of its own. The input is stalled while a copy or close runs, and
// while the output register holds a result that the receiver stalls.
// Reset returns to the token phase with capacity at its maximum; history
// content is kept undefined until written. cfg_data writes the output
// capacity (clamped to the maximum) and should only be written while idle.
module lz4_block_decompressor #(
    parameter int HISTORY_DEPTH = lz4bd_pkg::HISTORY_DEPTH_DEF,
    parameter int OUT_LANES     = lz4bd_pkg::OUT_LANES_DEF,
    parameter int MAX_OUTPUT    = lz4bd_pkg::MAX_OUTPUT_DEF
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               in_valid,
    output logic                               in_stall,
    input  logic [lz4bd_pkg::BYTE_W-1:0]       data_byte,
    input  logic                               is_last,
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [lz4bd_pkg::LEN_W-1:0]        cfg_data,
    output logic                               out_valid,
    input  logic                               out_stall,
    output logic [lz4bd_pkg::BYTE_W-1:0]       out_byte0,
    output logic [lz4bd_pkg::BYTE_W-1:0]       out_byte1,
    output logic [lz4bd_pkg::BYTE_W-1:0]       out_byte2,
    output logic [lz4bd_pkg::BYTE_W-1:0]       out_byte3,
    output logic [lz4bd_pkg::BYTE_W-1:0]       out_byte4,
    output logic [lz4bd_pkg::BYTE_W-1:0]       out_byte5,
    output logic [lz4bd_pkg::BYTE_W-1:0]       out_byte6,
    output logic [lz4bd_pkg::BYTE_W-1:0]       out_byte7,
    output logic [lz4bd_pkg::COUNT_W-1:0]      byte_count,
    output logic [lz4bd_pkg::STATUS_W-1:0]     status,
    output logic [lz4bd_pkg::LEN_W-1:0]        total_length,
    output logic                               end_of_block
);

    localparam int AW    = $clog2(HISTORY_DEPTH);
    localparam int NL    = (OUT_LANES < 1) ? 1 : ((OUT_LANES > 8) ? 8 : OUT_LANES);
    localparam int CAP_W = $clog2(MAX_OUTPUT + 1);
    localparam int BW    = lz4bd_pkg::BYTE_W;
    localparam int LW    = lz4bd_pkg::LEN_W;
    localparam int CW    = lz4bd_pkg::COUNT_W;
    localparam int SW    = lz4bd_pkg::STATUS_W;
    localparam int PL    = lz4bd_pkg::PORT_LANES;

    typedef enum logic [2:0] {
        PH_TOKEN, PH_LITEXT, PH_LIT, PH_OFFLO, PH_OFFHI, PH_MLEXT, PH_DRAIN
    } phase_t;

    typedef enum logic [1:0] {C_IN, C_COPY, C_PUSH, C_CLOSE} ctrl_t;

    // history memory
    logic [BW-1:0] hist_mem [HISTORY_DEPTH];
    logic [BW-1:0] hist_q;
    logic          rd_en, wr_en;
    logic [AW-1:0] rd_addr, wr_addr;
    logic [BW-1:0] wr_data;

    // state
    ctrl_t              ctrl_reg, ctrl_next;
    phase_t             phase_reg, phase_next;
    logic [CAP_W-1:0]   cap_reg, cap_next;
    logic [LW-1:0]      cnt_reg, cnt_next;
    logic [BW-1:0]      token_reg, token_next;
    logic [LW-1:0]      run_reg, run_next;
    logic [15:0]        off_reg, off_next;
    logic               err_reg, err_next;
    logic [SW-1:0]      code_reg, code_next;
    logic               last_reg, last_next;
    logic [8:0]         left_reg, left_next;
    logic [CW-1:0]      chunk_reg, chunk_next;
    logic [CW-1:0]      iss_reg, iss_next;
    logic [CW-1:0]      rcv_reg, rcv_next;
    logic [AW-1:0]      src_reg, src_next;
    logic               pend_reg, pend_next;
    logic               fwd_reg, fwd_next;
    logic [BW-1:0]      lastw_reg, lastw_next;
    logic [BW-1:0]      buf_reg [PL];
    logic [BW-1:0]      buf_next [PL];

    // output register
    logic               ov_reg, ov_next;
    logic [BW-1:0]      ob_reg [PL];
    logic [BW-1:0]      ob_next [PL];
    logic [CW-1:0]      oc_reg, oc_next;
    logic [SW-1:0]      os_reg, os_next;
    logic [LW-1:0]      ot_reg, ot_next;
    logic               oe_reg, oe_next;

    logic out_free, in_fire;
    assign out_free  = !ov_reg || !out_stall;
    assign in_stall  = !(ctrl_reg == C_IN && out_free);
    assign in_fire   = in_valid && !in_stall;
    assign cfg_ready = 1'b1;

    function automatic logic room(input logic [LW-1:0] cnt, input logic [LW:0] n,
                                  input logic [CAP_W-1:0] cap);
        return (33'(cnt) + 33'(n)) <= 33'(cap);
    endfunction

    function automatic logic [CW-1:0] first_chunk(input logic [8:0] n);
        return (n > 9'(NL)) ? CW'(NL) : CW'(n);
    endfunction

    // memory port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            hist_mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            hist_q <= hist_mem[rd_addr];
        end
    end

    // next-state logic
    always_comb
    begin
        logic [LW:0]    ext_sum;
        logic [15:0]    full_off;
        logic [8:0]     mlen;
        logic [BW-1:0]  cp_data;
        logic           start_copy;
        logic [CW-1:0]  rcv_inc;
        logic [8:0]     left_after;

        ctrl_next  = ctrl_reg;
        phase_next = phase_reg;
        cap_next   = cap_reg;
        cnt_next   = cnt_reg;
        token_next = token_reg;
        run_next   = run_reg;
        off_next   = off_reg;
        err_next   = err_reg;
        code_next  = code_reg;
        last_next  = last_reg;
        left_next  = left_reg;
        chunk_next = chunk_reg;
        iss_next   = iss_reg;
        rcv_next   = rcv_reg;
        src_next   = src_reg;
        pend_next  = 1'b0;
        fwd_next   = 1'b0;
        lastw_next = lastw_reg;
        buf_next   = buf_reg;
        ov_next    = ov_reg && out_stall;
        ob_next    = ob_reg;
        oc_next    = oc_reg;
        os_next    = os_reg;
        ot_next    = ot_reg;
        oe_next    = oe_reg;
        rd_en      = 1'b0;
        rd_addr    = src_reg;
        wr_en      = 1'b0;
        wr_addr    = cnt_reg[AW-1:0];
        wr_data    = data_byte;
        ext_sum    = {1'b0, run_reg} + (LW+1)'(data_byte);
        full_off   = {data_byte, off_reg[7:0]};
        mlen       = 9'(token_reg[3:0]) + 9'(lz4bd_pkg::MIN_MATCH);
        cp_data    = fwd_reg ? lastw_reg : hist_q;
        start_copy = 1'b0;
        rcv_inc    = rcv_reg;
        left_after = left_reg - 9'(chunk_reg);

        // write the capacity register, clamped
        if (cfg_valid)
        begin
            if (33'(cfg_data) > 33'(MAX_OUTPUT))
            begin
                cap_next = CAP_W'(MAX_OUTPUT);
            end
            else
            begin
                cap_next = CAP_W'(cfg_data);
            end
        end

        unique case (ctrl_reg)
            C_IN:
            begin
                if (in_fire)
                begin
                    last_next = is_last;
                    unique case (phase_reg)
                        PH_TOKEN:
                        begin
                            token_next = data_byte;
                            run_next   = LW'(data_byte[7:4]);
                            if (data_byte[7:4] == lz4bd_pkg::NIB_EXT)
                            begin
                                phase_next = PH_LITEXT;
                            end
                            else if (!room(cnt_reg, (LW+1)'(data_byte[7:4]), cap_reg))
                            begin
                                phase_next = PH_DRAIN;
                                err_next   = 1'b1;
                                code_next  = lz4bd_pkg::ST_OVF;
                            end
                            else
                            begin
                                phase_next = (data_byte[7:4] == 4'd0) ? PH_OFFLO : PH_LIT;
                            end
                        end
                        PH_LITEXT:
                        begin
                            run_next = ext_sum[LW-1:0];
                            if (!room(cnt_reg, ext_sum, cap_reg))
                            begin
                                phase_next = PH_DRAIN;
                                err_next   = 1'b1;
                                code_next  = lz4bd_pkg::ST_OVF;
                            end
                            else if (data_byte != lz4bd_pkg::BYTE_EXT)
                            begin
                                phase_next = (ext_sum == '0) ? PH_OFFLO : PH_LIT;
                            end
                        end
                        PH_LIT:
                        begin
                            wr_en      = 1'b1;
                            cnt_next   = cnt_reg + LW'(1);
                            ov_next    = 1'b1;
                            ob_next[0] = data_byte;
                            for (int i = 1; i < PL; i++)
                            begin
                                ob_next[i] = '0;
                            end
                            oc_next  = CW'(1);
                            os_next  = lz4bd_pkg::ST_DATA;
                            ot_next  = cnt_reg + LW'(1);
                            oe_next  = 1'b0;
                            run_next = run_reg - LW'(1);
                            if (run_reg == LW'(1))
                            begin
                                phase_next = PH_OFFLO;
                            end
                        end
                        PH_OFFLO:
                        begin
                            off_next   = {8'd0, data_byte};
                            phase_next = PH_OFFHI;
                        end
                        PH_OFFHI:
                        begin
                            off_next = full_off;
                            if (full_off == 16'd0 || LW'(full_off) > cnt_reg)
                            begin
                                phase_next = PH_DRAIN;
                                err_next   = 1'b1;
                                code_next  = lz4bd_pkg::ST_BADOFF;
                            end
                            else if (!room(cnt_reg, (LW+1)'(mlen), cap_reg))
                            begin
                                phase_next = PH_DRAIN;
                                err_next   = 1'b1;
                                code_next  = lz4bd_pkg::ST_OVF;
                            end
                            else
                            begin
                                start_copy = 1'b1;
                                left_next  = mlen;
                                src_next   = AW'(cnt_reg - LW'(full_off));
                                phase_next = (token_reg[3:0] == lz4bd_pkg::NIB_EXT) ?
                                             PH_MLEXT : PH_TOKEN;
                            end
                        end
                        PH_MLEXT:
                        begin
                            if (!room(cnt_reg, (LW+1)'(data_byte), cap_reg))
                            begin
                                phase_next = PH_DRAIN;
                                err_next   = 1'b1;
                                code_next  = lz4bd_pkg::ST_OVF;
                            end
                            else
                            begin
                                start_copy = (data_byte != 8'd0);
                                left_next  = 9'(data_byte);
                                src_next   = AW'(cnt_reg - LW'(off_reg));
                                if (data_byte != lz4bd_pkg::BYTE_EXT)
                                begin
                                    phase_next = PH_TOKEN;
                                end
                            end
                        end
                        default:
                        begin
                            phase_next = PH_DRAIN;
                        end
                    endcase
                    // hold first error code
                    if (err_reg)
                    begin
                        code_next = code_reg;
                    end
                    if (start_copy)
                    begin
                        chunk_next = first_chunk(left_next);
                        iss_next   = '0;
                        rcv_next   = '0;
                        ctrl_next  = C_COPY;
                    end
                    else if (is_last)
                    begin
                        ctrl_next = C_CLOSE;
                    end
                end
            end
            C_COPY:
            begin
                // issue the next read of this chunk
                if (iss_reg != chunk_reg)
                begin
                    rd_en     = 1'b1;
                    src_next  = src_reg + AW'(1);
                    iss_next  = iss_reg + CW'(1);
                    pend_next = 1'b1;
                end
                // take returned data, write it back and collect it
                if (pend_reg)
                begin
                    wr_en      = 1'b1;
                    wr_data    = cp_data;
                    lastw_next = cp_data;
                    cnt_next   = cnt_reg + LW'(1);
                    buf_next[rcv_reg[2:0]] = cp_data;
                    rcv_inc    = rcv_reg + CW'(1);
                end
                rcv_next = rcv_inc;
                fwd_next = rd_en && wr_en && (rd_addr == wr_addr);
                if (rcv_inc == chunk_reg)
                begin
                    ctrl_next = C_PUSH;
                end
            end
            C_PUSH:
            begin
                if (out_free)
                begin
                    ov_next = 1'b1;
                    for (int i = 0; i < PL; i++)
                    begin
                        ob_next[i] = (CW'(i) < chunk_reg) ? buf_reg[i] : '0;
                    end
                    oc_next   = chunk_reg;
                    os_next   = lz4bd_pkg::ST_DATA;
                    ot_next   = cnt_reg;
                    oe_next   = 1'b0;
                    left_next = left_after;
                    if (left_after == 9'd0)
                    begin
                        ctrl_next = last_reg ? C_CLOSE : C_IN;
                    end
                    else
                    begin
                        chunk_next = first_chunk(left_after);
                        iss_next   = '0;
                        rcv_next   = '0;
                        ctrl_next  = C_COPY;
                    end
                end
            end
            C_CLOSE:
            begin
                if (out_free)
                begin
                    ov_next = 1'b1;
                    for (int i = 0; i < PL; i++)
                    begin
                        ob_next[i] = '0;
                    end
                    oc_next = '0;
                    priority if (err_reg)
                    begin
                        os_next = code_reg;
                    end
                    else if (phase_reg == PH_TOKEN || phase_reg == PH_OFFLO)
                    begin
                        os_next = lz4bd_pkg::ST_DONE;
                    end
                    else
                    begin
                        os_next = lz4bd_pkg::ST_TRUNC;
                    end
                    ot_next    = cnt_reg;
                    oe_next    = 1'b1;
                    cnt_next   = '0;
                    phase_next = PH_TOKEN;
                    token_next = '0;
                    run_next   = '0;
                    off_next   = '0;
                    err_next   = 1'b0;
                    code_next  = lz4bd_pkg::ST_DATA;
                    ctrl_next  = C_IN;
                end
            end
            default:
            begin
                ctrl_next = C_IN;
            end
        endcase
    end

    // hold state and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctrl_reg  <= C_IN;
            phase_reg <= PH_TOKEN;
            cap_reg   <= CAP_W'(MAX_OUTPUT);
            cnt_reg   <= '0;
            token_reg <= '0;
            run_reg   <= '0;
            off_reg   <= '0;
            err_reg   <= 1'b0;
            code_reg  <= lz4bd_pkg::ST_DATA;
            last_reg  <= 1'b0;
            left_reg  <= '0;
            chunk_reg <= '0;
            iss_reg   <= '0;
            rcv_reg   <= '0;
            pend_reg  <= 1'b0;
            fwd_reg   <= 1'b0;
            ov_reg    <= 1'b0;
        end
        else
        begin
            ctrl_reg  <= ctrl_next;
            phase_reg <= phase_next;
            cap_reg   <= cap_next;
            cnt_reg   <= cnt_next;
            token_reg <= token_next;
            run_reg   <= run_next;
            off_reg   <= off_next;
            err_reg   <= err_next;
            code_reg  <= code_next;
            last_reg  <= last_next;
            left_reg  <= left_next;
            chunk_reg <= chunk_next;
            iss_reg   <= iss_next;
            rcv_reg   <= rcv_next;
            pend_reg  <= pend_next;
            fwd_reg   <= fwd_next;
            ov_reg    <= ov_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        src_reg   <= src_next;
        lastw_reg <= lastw_next;
        buf_reg   <= buf_next;
        ob_reg    <= ob_next;
        oc_reg    <= oc_next;
        os_reg    <= os_next;
        ot_reg    <= ot_next;
        oe_reg    <= oe_next;
    end

    assign out_valid    = ov_reg;
    assign out_byte0    = ob_reg[0];
    assign out_byte1    = ob_reg[1];
    assign out_byte2    = ob_reg[2];
    assign out_byte3    = ob_reg[3];
    assign out_byte4    = ob_reg[4];
    assign out_byte5    = ob_reg[5];
    assign out_byte6    = ob_reg[6];
    assign out_byte7    = ob_reg[7];
    assign byte_count   = oc_reg;
    assign status       = os_reg;
    assign total_length = ot_reg;
    assign end_of_block = oe_reg;

`ifndef SYNTHESIS
    a_err_drains: assert property (@(posedge clk) disable iff (!rst_n)
        err_reg && ctrl_reg != C_CLOSE |-> phase_reg == PH_DRAIN)
        else $error("error seen but parser not draining");
    a_busy_stalls: assert property (@(posedge clk) disable iff (!rst_n)
        ctrl_reg != C_IN |-> in_stall)
        else $error("input taken during copy or close");
    a_chunk_bound: assert property (@(posedge clk) disable iff (!rst_n)
        ov_reg |-> oc_reg <= CW'(NL))
        else $error("chunk wider than lane count");
    a_close_empty: assert property (@(posedge clk) disable iff (!rst_n)
        ov_reg && oe_reg |-> oc_reg == '0 && os_reg != lz4bd_pkg::ST_DATA)
        else $error("closing result carries data");
    a_read_in_copy: assert property (@(posedge clk) disable iff (!rst_n)
        pend_reg |-> ctrl_reg == C_COPY)
        else $error("history read returned outside a copy");
`endif

endmodule

// File: tb/tb_top.sv
// Self-checking testbench for the LZ4 block decompressor: predicts every chunk and closing result.
`timescale 1ns / 1ps

module tb_top;

    typedef enum logic [2:0] {
        PH_TOKEN, PH_LITEXT, PH_LIT, PH_OFFLO, PH_OFFHI, PH_MLEXT, PH_DRAIN
    } dec_phase_t;

    typedef struct packed {
        logic [7:0][7:0]                lanes;
        logic [lz4bd_pkg::COUNT_W-1:0]  n;
        logic [lz4bd_pkg::STATUS_W-1:0] st;
        logic [lz4bd_pkg::LEN_W-1:0]    tot;
        logic                           eob;
    } chunk_t;

    localparam int unsigned CAP_MAX = lz4bd_pkg::MAX_OUTPUT_DEF;

    logic                           clk = 1'b0;
    logic                           rst_n = 1'b0;
    logic                           in_valid = 1'b0;
    logic                           in_stall;
    logic [lz4bd_pkg::BYTE_W-1:0]   data_byte = '0;
    logic                           is_last = 1'b0;
    logic                           cfg_valid = 1'b0;
    logic                           cfg_ready;
    logic [lz4bd_pkg::LEN_W-1:0]    cfg_data = '0;
    logic                           out_valid;
    logic                           out_stall = 1'b0;
    logic [lz4bd_pkg::BYTE_W-1:0]   out_byte0, out_byte1, out_byte2, out_byte3;
    logic [lz4bd_pkg::BYTE_W-1:0]   out_byte4, out_byte5, out_byte6, out_byte7;
    logic [lz4bd_pkg::COUNT_W-1:0]  byte_count;
    logic [lz4bd_pkg::STATUS_W-1:0] status;
    logic [lz4bd_pkg::LEN_W-1:0]    total_length;
    logic                           end_of_block;

    lz4_block_decompressor u_top (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall),
        .data_byte(data_byte), .is_last(is_last),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
        .out_valid(out_valid), .out_stall(out_stall),
        .out_byte0(out_byte0), .out_byte1(out_byte1), .out_byte2(out_byte2),
        .out_byte3(out_byte3), .out_byte4(out_byte4), .out_byte5(out_byte5),
        .out_byte6(out_byte6), .out_byte7(out_byte7),
        .byte_count(byte_count), .status(status),
        .total_length(total_length), .end_of_block(end_of_block)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // decoder state mirrored for prediction
    logic [7:0]     hist [0:65535];
    int unsigned    dec_count, dec_run, dec_cap;
    logic [15:0]    dec_off;
    logic [7:0]     dec_token;
    dec_phase_t     dec_phase;
    bit             dec_err;
    logic [2:0]     dec_code;
    chunk_t         chunk_q[$];

    int fails = 0, items_sent = 0, blocks_sent = 0, chunks_seen = 0, errs_seen = 0;
    bit calm = 1'b0;

    function automatic int pick_gap();
        int r;
        if (calm)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    task automatic emit(logic [7:0][7:0] lanes, int n, logic [2:0] st, bit eob);
        chunk_t c;
        c.lanes = lanes;
        c.n = n[lz4bd_pkg::COUNT_W-1:0];
        c.st = st;
        c.tot = dec_count[lz4bd_pkg::LEN_W-1:0];
        c.eob = eob;
        chunk_q.push_back(c);
    endtask

    task automatic raise(logic [2:0] code);
        if (!dec_err)
        begin
            dec_err = 1'b1;
            dec_code = code;
        end
        dec_phase = PH_DRAIN;
    endtask

    // copy a match out of history in chunks of eight
    task automatic copy_run(int unsigned n);
        logic [7:0][7:0] lanes;
        int fill;
        logic [7:0] v;
        logic [15:0] idx;
        if (dec_count + n > dec_cap)
        begin
            raise(lz4bd_pkg::ST_OVF);
            return;
        end
        lanes = '0;
        fill = 0;
        while (n > 0)
        begin
            idx = dec_count[15:0] - dec_off;
            v = hist[idx];
            hist[dec_count[15:0]] = v;
            dec_count++;
            lanes[fill] = v;
            fill++;
            n--;
            if (fill == 8 || n == 0)
            begin
                emit(lanes, fill, lz4bd_pkg::ST_DATA, 1'b0);
                lanes = '0;
                fill = 0;
            end
        end
    endtask

    task automatic start_literals();
        if (dec_count + dec_run > dec_cap)
            raise(lz4bd_pkg::ST_OVF);
        else if (dec_run == 0)
            dec_phase = PH_OFFLO;
        else
            dec_phase = PH_LIT;
    endtask

    task automatic clear_block();
        dec_count = 0;
        dec_phase = PH_TOKEN;
        dec_token = '0;
        dec_run = 0;
        dec_off = '0;
        dec_err = 1'b0;
        dec_code = lz4bd_pkg::ST_DATA;
    endtask

    // advance the decoder by one accepted byte
    task automatic decode_byte(logic [7:0] b, bit last);
        logic [7:0][7:0] lanes;
        logic [2:0] st;
        lanes = '0;
        case (dec_phase)
            PH_TOKEN:
            begin
                dec_token = b;
                dec_run = 32'(b[7:4]);
                if (b[7:4] == lz4bd_pkg::NIB_EXT)
                    dec_phase = PH_LITEXT;
                else
                    start_literals();
            end
            PH_LITEXT:
            begin
                dec_run += 32'(b);
                if (dec_count + dec_run > dec_cap)
                    raise(lz4bd_pkg::ST_OVF);
                else if (b != lz4bd_pkg::BYTE_EXT)
                    start_literals();
            end
            PH_LIT:
            begin
                hist[dec_count[15:0]] = b;
                dec_count++;
                lanes[0] = b;
                emit(lanes, 1, lz4bd_pkg::ST_DATA, 1'b0);
                dec_run--;
                if (dec_run == 0)
                    dec_phase = PH_OFFLO;
            end
            PH_OFFLO:
            begin
                dec_off = {8'h00, b};
                dec_phase = PH_OFFHI;
            end
            PH_OFFHI:
            begin
                dec_off[15:8] = b;
                if (dec_off == 0 || dec_off > dec_count)
                    raise(lz4bd_pkg::ST_BADOFF);
                else
                begin
                    copy_run(32'(dec_token[3:0]) + lz4bd_pkg::MIN_MATCH);
                    if (!dec_err)
                        dec_phase = (dec_token[3:0] == lz4bd_pkg::NIB_EXT) ?
                                    PH_MLEXT : PH_TOKEN;
                end
            end
            PH_MLEXT:
            begin
                copy_run(32'(b));
                if (!dec_err && b != lz4bd_pkg::BYTE_EXT)
                    dec_phase = PH_TOKEN;
            end
            default: dec_phase = PH_DRAIN;
        endcase
        if (last)
        begin
            if (dec_err)
                st = dec_code;
            else if (dec_phase == PH_TOKEN || dec_phase == PH_OFFLO)
                st = lz4bd_pkg::ST_DONE;
            else
                st = lz4bd_pkg::ST_TRUNC;
            emit('0, 0, st, 1'b1);
            clear_block();
        end
    endtask

    // send one byte request and wait until it is taken
    task automatic send_item(logic [7:0] b, bit last);
        int gap;
        bit held;
        gap = pick_gap();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        data_byte <= b;
        is_last <= last;
        do
        begin
            @(negedge clk);
            held = in_stall;
            @(posedge clk);
        end
        while (held);
        decode_byte(b, last);
        items_sent++;
    endtask

    task automatic send_block(logic [7:0] bq[$]);
        foreach (bq[i])
            send_item(bq[i], i == bq.size() - 1);
        blocks_sent++;
    endtask

    task automatic wait_idle();
        in_valid <= 1'b0;
        while (chunk_q.size() != 0)
            @(posedge clk);
        repeat (60) @(posedge clk);
    endtask

    task automatic set_capacity(logic [lz4bd_pkg::LEN_W-1:0] v);
        bit held;
        wait_idle();
        cfg_valid <= 1'b1;
        cfg_data <= v;
        do
        begin
            @(negedge clk);
            held = !cfg_ready;
            @(posedge clk);
        end
        while (held);
        cfg_valid <= 1'b0;
        dec_cap = (v > CAP_MAX) ? CAP_MAX : v;
    endtask

    // build a well-formed block with random content (or, rarely, a short run of random bytes), then maybe break it
    task automatic make_block(output logic [7:0] bq[$]);
        int unsigned gcount, lit, mlen, off, nseq, ext;
        logic [3:0] lo;
        int r;
        bit final_lits;
        bq = {};
        gcount = 0;
        if ($urandom_range(0, 99) < 8)
        begin
            repeat ($urandom_range(1, 12)) bq.push_back(8'($urandom));
            return;
        end
        nseq = $urandom_range(1, 4);
        for (int s = 0; s < nseq; s++)
        begin
            r = $urandom_range(0, 99);
            lit = (r < 75) ? $urandom_range(0, 14) : $urandom_range(15, 50);
            if (gcount == 0 && lit == 0)
                lit = 1;
            lo = 4'($urandom);
            final_lits = (s == nseq - 1) && $urandom_range(0, 1);
            bq.push_back({(lit >= 15) ? 4'd15 : lit[3:0], lo});
            if (lit >= 15)
                bq.push_back(8'(lit - 15));
            repeat (lit) bq.push_back(8'($urandom));
            gcount += lit;
            if (final_lits)
                break;
            off = $urandom_range(0, 1) ? $urandom_range(1, (gcount < 4) ? gcount : 4)
                                       : $urandom_range(1, gcount);
            bq.push_back(off[7:0]);
            bq.push_back(off[15:8]);
            mlen = 32'(lo) + lz4bd_pkg::MIN_MATCH;
            if (lo == lz4bd_pkg::NIB_EXT)
            begin
                if ($urandom_range(0, 9) == 0)
                begin
                    bq.push_back(lz4bd_pkg::BYTE_EXT);
                    mlen += 255;
                end
                ext = $urandom_range(0, 30);
                bq.push_back(8'(ext));
                mlen += ext;
            end
            gcount += mlen;
        end
        r = $urandom_range(0, 99);
        if (r < 10 && bq.size() > 1)
            bq = bq[0:$urandom_range(0, bq.size() - 2)];
        else if (r < 20)
            bq[$urandom_range(0, bq.size() - 1)] = 8'($urandom);
    endtask

    task automatic test_directed_forms();
        send_block('{8'h00});
        send_block('{8'h42, 8'h11, 8'h22, 8'h33, 8'h44, 8'h02, 8'h00, 8'h10, 8'hFF});
        send_block('{8'h1F, 8'hAA, 8'h01, 8'h00, 8'hFF, 8'h03});
        send_block('{8'h14, 8'h55, 8'h00, 8'h00, 8'h77, 8'h88});
        send_block('{8'h20, 8'h01, 8'h02, 8'h05, 8'h00});
        send_block('{8'h50, 8'h01, 8'h02});
        send_block('{8'h10, 8'h07, 8'h01});
    endtask

    task automatic test_capacity_limits();
        set_capacity(20);
        send_block('{8'hF0, 8'hFF, 8'h05});
        send_block('{8'h4F, 8'h01, 8'h02, 8'h03, 8'h04, 8'h04, 8'h00, 8'h00});
        set_capacity(0);
        send_block('{8'h10, 8'h99});
        send_block('{8'h00});
        set_capacity({lz4bd_pkg::LEN_W{1'b1}});
    endtask

    task automatic test_random_traffic(int target, bit quiet);
        logic [7:0] bq[$];
        calm = quiet;
        while (items_sent < target)
        begin
            make_block(bq);
            send_block(bq);
        end
        calm = 1'b0;
    endtask

    // receiver stalls in bursts
    int stall_left = 0;
    always @(posedge clk)
    begin
        if (stall_left != 0)
            stall_left <= stall_left - 1;
        else
        begin
            stall_left <= pick_gap();
            out_stall <= (pick_gap() != 0);
        end
    end

    task automatic check_field(string name, longint want, longint got);
        if (want != got)
        begin
            $error("%s: expected %0d, got %0d", name, want, got);
            fails++;
        end
    endtask

    // compare each taken result with the oldest prediction
    always @(negedge clk)
    begin
        chunk_t c;
        if (rst_n && out_valid && !out_stall)
        begin
            chunks_seen++;
            if (chunk_q.size() == 0)
            begin
                $error("result with nothing predicted: status %0d", status);
                fails++;
            end
            else
            begin
                c = chunk_q.pop_front();
                check_field("out_byte0", c.lanes[0], out_byte0);
                check_field("out_byte1", c.lanes[1], out_byte1);
                check_field("out_byte2", c.lanes[2], out_byte2);
                check_field("out_byte3", c.lanes[3], out_byte3);
                check_field("out_byte4", c.lanes[4], out_byte4);
                check_field("out_byte5", c.lanes[5], out_byte5);
                check_field("out_byte6", c.lanes[6], out_byte6);
                check_field("out_byte7", c.lanes[7], out_byte7);
                check_field("byte_count", c.n, byte_count);
                check_field("status", c.st, status);
                check_field("total_length", c.tot, total_length);
                check_field("end_of_block", c.eob, end_of_block);
                if (c.st > lz4bd_pkg::ST_DONE)
                    errs_seen++;
            end
        end
    end

    initial
    begin
        #40_000_000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    initial
    begin
        dec_cap = CAP_MAX;
        clear_block();
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed_forms();
        test_capacity_limits();
        test_random_traffic(180, 1'b0);
        set_capacity(40);
        test_random_traffic(240, 1'b0);
        set_capacity($urandom_range(60, 400));
        test_random_traffic(290, 1'b1);
        set_capacity(CAP_MAX);
        test_random_traffic(420, 1'b0);
        wait_idle();
        $display("Sent %0d bytes in %0d blocks under five capacity settings;",
                 items_sent, blocks_sent);
        $display("checked %0d results, %0d of them error closes.", chunks_seen, errs_seen);
        if (fails == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
